// ===== src/sine_cosine_chebyshev_defines.svh =====
// Assertion macros shared by the sine/cosine checker.
`ifndef SINE_COSINE_CHEBYSHEV_DEFINES_SVH
`define SINE_COSINE_CHEBYSHEV_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define SCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An antecedent that must be followed by a consequent after a fixed delay.
`define SCC_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== src/scc_pkg.sv =====
// Types, widths and series coefficients for the sine/cosine pipeline.
`default_nettype none
package scc_pkg;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 24;
  localparam int W_W     = 32;  // w and z, Q2.30
  localparam int T_W     = 34;  // Chebyshev terms, Q2.30 with headroom
  localparam int P_W     = 36;  // series sum, Q.32
  localparam int NTERMS  = 5;

  // 1/(2*pi) as Q0.32.
  localparam logic signed [30:0] INV_TWO_PI = 31'sd683565276;
  localparam logic signed [W_W-1:0] ONE_Q30 = 32'sd1073741824;
  // Constant term of the series, Q.32.
  localparam logic signed [P_W-1:0] COEF0 = 36'sd5481576402;

  typedef struct packed {
    logic                  vld;
    logic signed [W_W-1:0] w;
    logic signed [W_W-1:0] z;
    logic signed [T_W-1:0] t_prev;
    logic signed [T_W-1:0] t_cur;
    logic signed [P_W-1:0] p;
  } series_t;

  // Twice the k-th series coefficient, Q.32.
  function automatic logic signed [W_W-1:0] term_coef(input logic [2:0] k);
    logic signed [W_W-1:0] c;
    case (k)
      3'd1:    c = -32'sd1225189114;
      3'd2:    c = 32'sd39161581;
      3'd3:    c = -32'sd586641;
      3'd4:    c = 32'sd5085;
      3'd5:    c = -32'sd26;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/scc_front.sv =====
// Front end: angle to turns, fraction and fold, then z = 2*w*w - 1.
`default_nettype none
module scc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [scc_pkg::ANGLE_W-1:0]  angle,
  input  logic                                req_type,
  output scc_pkg::series_t                    out_s
);

  // Stage 1: angle times 1/(2*pi).
  logic                s1_vld;
  logic                s1_cos;
  logic signed [62:0]  s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_cos  <= req_type;
    s1_prod <= angle * scc_pkg::INV_TWO_PI;
  end

  // Stage 2: round to Q.32 turns, add a quarter turn for cosine.
  logic                s2_vld;
  logic signed [39:0]  s2_turns;
  logic signed [62:0]  tsum;
  logic signed [38:0]  t_base;

  assign tsum   = s1_prod + 63'sd8388608;
  assign t_base = tsum[62:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_turns <= {t_base[38], t_base} + (s1_cos ? 40'sd1073741824 : 40'sd0);
  end

  // Stage 3: keep the fraction and fold it into [-1, 1] in Q2.30.
  // An exact half turn reads as -0.5 here and folds to zero, which is
  // the same answer that +0.5 would give.
  logic                    s3_vld;
  logic signed [scc_pkg::W_W-1:0] s3_w;
  logic signed [32:0]      y;
  logic signed [32:0]      w_fold;

  assign y = {s2_turns[31], s2_turns[31:0]};

  always_comb begin
    if (y > 33'sd1073741824) begin
      w_fold = 33'sd2147483648 - y;
    end else if (y < -33'sd1073741824) begin
      w_fold = -33'sd2147483648 - y;
    end else begin
      w_fold = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_w <= w_fold[31:0];
  end

  // Stage 4: square of w.
  logic                    s4_vld;
  logic signed [scc_pkg::W_W-1:0] s4_w;
  logic signed [63:0]      s4_ww;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_w  <= s3_w;
    s4_ww <= s3_w * s3_w;
  end

  // Stage 5: z = 2*round(w*w) - 1.
  logic                    s5_vld;
  logic signed [scc_pkg::W_W-1:0] s5_w;
  logic signed [scc_pkg::W_W-1:0] s5_z;
  logic signed [63:0]      wsum;
  logic signed [33:0]      wr;
  logic signed [33:0]      z_full;

  assign wsum   = s4_ww + 64'sd536870912;
  assign wr     = wsum[63:30];
  assign z_full = {wr[32:0], 1'b0} - 34'sd1073741824;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_w <= s4_w;
    s5_z <= z_full[31:0];
  end

  always_comb begin
    out_s.vld    = s5_vld;
    out_s.w      = s5_w;
    out_s.z      = s5_z;
    out_s.t_prev = {{(scc_pkg::T_W - scc_pkg::W_W){scc_pkg::ONE_Q30[scc_pkg::W_W-1]}},
                    scc_pkg::ONE_Q30};
    out_s.t_cur  = {{(scc_pkg::T_W - scc_pkg::W_W){s5_z[scc_pkg::W_W-1]}}, s5_z};
    out_s.p      = scc_pkg::COEF0;
  end

endmodule
`default_nettype wire

// ===== src/scc_term.sv =====
// One series term: accumulate coef*T(k) and step the Chebyshev recurrence.
`default_nettype none
module scc_term (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [scc_pkg::W_W-1:0] coef,
  input  scc_pkg::series_t               in_s,
  output scc_pkg::series_t               out_s
);

  logic signed [scc_pkg::T_W-1:0] t_cur_in;
  logic signed [scc_pkg::W_W-1:0] z_in;

  assign t_cur_in = in_s.t_cur;
  assign z_in     = in_s.z;

  // Stage A: both products of this term.
  logic                a_vld;
  scc_pkg::series_t    a_s;
  logic signed [65:0]  a_pc;
  logic signed [65:0]  a_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    a_s  <= in_s;
    a_pc <= coef * t_cur_in;
    a_pz <= z_in * t_cur_in;
  end

  // Stage B: round both products, add to the sum, form T(k+1).
  logic                            b_vld;
  logic signed [scc_pkg::W_W-1:0]  b_w;
  logic signed [scc_pkg::W_W-1:0]  b_z;
  logic signed [scc_pkg::T_W-1:0]  b_t_prev;
  logic signed [scc_pkg::T_W-1:0]  b_t_cur;
  logic signed [scc_pkg::P_W-1:0]  b_p;
  logic signed [65:0]              pc_sum;
  logic signed [65:0]              pz_sum;
  logic signed [35:0]              pc_r;
  logic signed [35:0]              pz_r;
  logic signed [scc_pkg::T_W-1:0]  a_t_prev;
  logic signed [35:0]              t_next;

  assign pc_sum   = a_pc + 66'sd536870912;
  assign pz_sum   = a_pz + 66'sd536870912;
  assign pc_r     = pc_sum[65:30];
  assign pz_r     = pz_sum[65:30];
  assign a_t_prev = a_s.t_prev;
  assign t_next   = {pz_r[34:0], 1'b0} - {{(36 - scc_pkg::T_W){a_t_prev[scc_pkg::T_W-1]}},
                                          a_t_prev};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_w      <= a_s.w;
    b_z      <= a_s.z;
    b_t_prev <= a_s.t_cur;
    b_t_cur  <= t_next[scc_pkg::T_W-1:0];
    b_p      <= a_s.p + pc_r;
  end

  always_comb begin
    out_s.vld    = b_vld;
    out_s.w      = b_w;
    out_s.z      = b_z;
    out_s.t_prev = b_t_prev;
    out_s.t_cur  = b_t_cur;
    out_s.p      = b_p;
  end

endmodule
`default_nettype wire

// ===== src/scc_back.sv =====
// Back end: w times the series sum, rounded to Q1.22 and saturated.
`default_nettype none
module scc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scc_pkg::series_t                     in_s,
  output logic                                 done,
  output logic signed [scc_pkg::VALUE_W-1:0]   value
);

  logic signed [scc_pkg::W_W-1:0] w_in;
  logic signed [33:0]             p_in;

  // The sum stays positive and below 2^33, so 34 signed bits carry it.
  assign w_in = in_s.w;
  assign p_in = in_s.p[33:0];

  logic                m_vld;
  logic signed [65:0]  m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= in_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    m_prod <= w_in * p_in;
  end

  logic signed [65:0]  vsum;
  logic signed [25:0]  v;
  logic signed [25:0]  v_sat;

  assign vsum = m_prod + 66'sd549755813888;
  assign v    = vsum[65:40];

  always_comb begin
    if (v > 26'sd4194304) begin
      v_sat = 26'sd4194304;
    end else if (v < -26'sd4194304) begin
      v_sat = -26'sd4194304;
    end else begin
      v_sat = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    value <= v_sat[scc_pkg::VALUE_W-1:0];
  end

endmodule
`default_nettype wire

// ===== src/sine_cosine_chebyshev.sv =====
// A beat taken with start shows on value with done once it has passed every register stage listed below.
// Throughput: one beat per cycle; busy is always low and every stage is a plain register.
// The stages are 5 front stages, two per series term for 5 terms, and 2 output stages.
// Reset clears every valid bit, so beats in flight are dropped and done stays low.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none
module sine_cosine_chebyshev (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [scc_pkg::ANGLE_W-1:0]  angle,
  input  logic                                req_type,
  output logic                                done,
  output logic signed [scc_pkg::VALUE_W-1:0]  value
);

  scc_pkg::series_t chain [scc_pkg::NTERMS+1];

  assign busy = 1'b0;

  scc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .angle    (angle),
    .req_type (req_type),
    .out_s    (chain[0])
  );

  for (genvar g = 0; g < scc_pkg::NTERMS; g++) begin : g_term
    scc_term u_term (
      .clk   (clk),
      .rst   (rst),
      .coef  (scc_pkg::term_coef(3'(g + 1))),
      .in_s  (chain[g]),
      .out_s (chain[g+1])
    );
  end

  scc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .in_s  (chain[scc_pkg::NTERMS]),
    .done  (done),
    .value (value)
  );

endmodule
`default_nettype wire

// ===== src/scc_check.sv =====
// Port-level checks for the sine/cosine pipeline, bound to the top level.
`default_nettype none
`include "sine_cosine_chebyshev_defines.svh"
module scc_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] angle,
  input logic               req_type,
  input logic               done,
  input logic signed [23:0] value
);

  localparam int LAT = 17;
  localparam logic signed [23:0] VALUE_MAX = 24'sd4194304;

  logic in_range;
  logic sin_zero_beat;

  assign in_range      = (value >= -VALUE_MAX) && (value <= VALUE_MAX);
  assign sin_zero_beat = start && !busy && angle == 32'sd0 && !req_type;

  // Every accepted beat comes out after the fixed latency.
  `SCC_ASSERT_DELAY(a_lat, clk, rst, start && !busy, LAT, done, "result missing")
  // No result appears without a beat taken the fixed latency earlier.
  `SCC_ASSERT(a_no_extra, clk, rst, done |-> $past(start, LAT), "result without input")
  // Results never leave the unit range.
  `SCC_ASSERT(a_range, clk, rst, done |-> in_range, "value out of range")
  // The sine of zero is exactly zero.
  `SCC_ASSERT_DELAY(a_sin_zero, clk, rst, sin_zero_beat, LAT, value == 24'sd0, "sine of zero not zero")

endmodule

bind sine_cosine_chebyshev scc_check u_scc_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .angle    (angle),
  .req_type (req_type),
  .done     (done),
  .value    (value)
);
`default_nettype wire
